FILE: hw/rtl/toroidal_life_generation_defines.svh
// Assertion macros used by the checker file of toroidal_life_generation.
`ifndef TOROIDAL_LIFE_GENERATION_DEFINES_SVH
`define TOROIDAL_LIFE_GENERATION_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TLG_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("toroidal_life_generation: check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TLG_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("toroidal_life_generation: check failed");

`endif

FILE: hw/rtl/tlg_pkg.sv
// Package for toroidal_life_generation: opcodes, register indexes, states, widths.
`default_nettype none

package tlg_pkg;

	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_ADVANCE = 2'd1,
		OP_READ    = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

	localparam logic REG_ROWS_USED = 1'b0;
	localparam logic REG_COLS_USED = 1'b1;

	localparam int ROWS_USED_W = 6;
	localparam int COLS_USED_W = 7;
	localparam int ROW_W       = 5;
	localparam int COL_W       = 6;

	localparam logic [ROWS_USED_W-1:0] ROWS_RESET = 6'd30;
	localparam logic [COLS_USED_W-1:0] COLS_RESET = 7'd50;

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_ACC   = 8'b0000_0100,
		S_GRD0  = 8'b0000_1000,
		S_GRD1  = 8'b0001_0000,
		S_GRDN  = 8'b0010_0000,
		S_GCELL = 8'b0100_0000,
		S_GWR   = 8'b1000_0000
	} state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tlg_grid_mem.sv
// Row-organized grid memory: one write port, one read port, registered read data.
`default_nettype none

module tlg_grid_mem #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/tlg_life_rule.sv
// Shared neighbor-count unit: next state of one cell from three buffered rows.
`default_nettype none

module tlg_life_rule #(
	parameter int MAX_COLS = 64
) (
	input  logic [MAX_COLS-1:0]                            row_up,
	input  logic [MAX_COLS-1:0]                            row_mid,
	input  logic [MAX_COLS-1:0]                            row_dn,
	input  logic [(MAX_COLS > 1 ? $clog2(MAX_COLS) : 1)-1:0] col,
	input  logic [$clog2(MAX_COLS + 1)-1:0]                ncols,
	output logic                                           next_alive
);

	localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int CCW = $clog2(MAX_COLS + 1);

	logic [CW-1:0] lf;
	logic [CW-1:0] rt;
	logic [3:0]    n;

	always_comb begin
		lf = (col == '0) ? CW'(ncols - CCW'(1)) : col - CW'(1);
		rt = (int'(col) + 1 == int'(ncols)) ? '0 : col + CW'(1);
		n  = 4'(row_up[lf]) + 4'(row_up[col]) + 4'(row_up[rt])
		   + 4'(row_mid[lf]) + 4'(row_mid[rt])
		   + 4'(row_dn[lf]) + 4'(row_dn[col]) + 4'(row_dn[rt]);
		next_alive = (n == 4'd3) || ((n == 4'd2) && row_mid[col]);
	end

endmodule

`default_nettype wire

FILE: hw/rtl/toroidal_life_generation.sv
// Top level of toroidal_life_generation: sequencer, config registers, result word.
//
// Command channel: a word (op, row, col, alive) is taken at a rising edge with
// start high and busy low. Ops: write cell, advance one generation, read cell.
// Result channel: done is high for exactly one cycle with cell_alive and
// out_of_range; the receiver cannot stall it, one result per command.
// Config: cfg_we writes cfg_data into rows_used (index 0) or cols_used
// (index 1) at once; write only while busy is low and no result is pending.
// Sequence from the accepting edge to done:
//   out-of-range access or unused op: done in the next cycle, busy stays low.
//   in-range read or write: one row read and, for a write only, one row write.
//   advance: two row loads up front, then per row (R rows, R and C the clamped
//   used size) one load, C cells through the single neighbor-count unit and
//   one write-back, then the result.
// Reset: the grid is cleared one row per cycle, all MAX_ROWS rows, with busy
// high; rows_used and cols_used return to 30 and 50.
`default_nettype none

module toroidal_life_generation #(
	parameter int MAX_ROWS = 32,
	parameter int MAX_COLS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      op,
	input  logic [tlg_pkg::ROW_W-1:0]       row,
	input  logic [tlg_pkg::COL_W-1:0]       col,
	input  logic                            alive,
	output logic                            done,
	output logic                            cell_alive,
	output logic                            out_of_range,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [tlg_pkg::COLS_USED_W-1:0] cfg_data
);

	import tlg_pkg::*;

	localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RCW = $clog2(MAX_ROWS + 1);
	localparam int CCW = $clog2(MAX_COLS + 1);

	state_t                  state_q;
	logic [ROWS_USED_W-1:0]  rows_used_q;
	logic [COLS_USED_W-1:0]  cols_used_q;
	op_t                     op_q;
	logic [RW-1:0]           row_q;
	logic [CW-1:0]           col_q;
	logic                    alive_q;
	logic [RW-1:0]           i_q;
	logic [CW-1:0]           j_q;
	logic [RW-1:0]           clr_q;
	logic [MAX_COLS-1:0]     prev_q;
	logic [MAX_COLS-1:0]     cur_q;
	logic [MAX_COLS-1:0]     next_q;
	logic [MAX_COLS-1:0]     first_q;
	logic [MAX_COLS-1:0]     new_q;
	logic                    done_q;
	logic                    cell_alive_q;
	logic                    oor_q;

	logic [RCW-1:0]          nr;
	logic [CCW-1:0]          nc;
	logic                    in_range;
	logic [RW-1:0]           dn_i;
	logic [RW-1:0]           dn_nxt;
	logic                    last_row;
	logic                    last_col;
	logic                    rule_bit;

	logic                    mem_we;
	logic [RW-1:0]           mem_waddr;
	logic [MAX_COLS-1:0]     mem_wdata;
	logic [RW-1:0]           mem_raddr;
	logic [MAX_COLS-1:0]     rd_data;

	// clamp used size to 1..MAX
	always_comb begin
		if (int'(rows_used_q) > MAX_ROWS) begin
			nr = RCW'(MAX_ROWS);
		end else if (rows_used_q == '0) begin
			nr = RCW'(1);
		end else begin
			nr = RCW'(rows_used_q);
		end
		if (int'(cols_used_q) > MAX_COLS) begin
			nc = CCW'(MAX_COLS);
		end else if (cols_used_q == '0) begin
			nc = CCW'(1);
		end else begin
			nc = CCW'(cols_used_q);
		end
	end

	assign in_range = (int'(row) < int'(nr)) && (int'(col) < int'(nc));
	assign dn_i     = (int'(i_q) + 1 == int'(nr)) ? '0 : i_q + RW'(1);
	assign dn_nxt   = (int'(i_q) + 2 == int'(nr)) ? '0 : RW'(int'(i_q) + 2);
	assign last_row = (int'(i_q) + 1 == int'(nr));
	assign last_col = (int'(j_q) + 1 == int'(nc));
	assign busy     = (state_q != S_IDLE);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = row_q;
		mem_wdata = rd_data;
		mem_raddr = row_q;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			S_IDLE: begin
				if (op_t'(op) == OP_ADVANCE) begin
					mem_raddr = RW'(nr - RCW'(1));
				end else begin
					mem_raddr = RW'(row);
				end
			end
			S_ACC: begin
				mem_we           = (op_q == OP_WRITE);
				mem_wdata[col_q] = alive_q;
			end
			S_GRD0: begin
				mem_raddr = '0;
			end
			S_GRD1: begin
				mem_raddr = dn_i;
			end
			S_GWR: begin
				mem_we    = 1'b1;
				mem_waddr = i_q;
				mem_wdata = new_q;
				mem_raddr = dn_nxt;
			end
			default: begin
			end
		endcase
	end

	tlg_grid_mem #(
		.DEPTH(MAX_ROWS),
		.WIDTH(MAX_COLS)
	) u_grid_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (rd_data)
	);

	tlg_life_rule #(
		.MAX_COLS(MAX_COLS)
	) u_life_rule (
		.row_up     (prev_q),
		.row_mid    (cur_q),
		.row_dn     (next_q),
		.col        (j_q),
		.ncols      (nc),
		.next_alive (rule_bit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			rows_used_q  <= ROWS_RESET;
			cols_used_q  <= COLS_RESET;
			op_q         <= OP_NOP;
			row_q        <= '0;
			col_q        <= '0;
			alive_q      <= 1'b0;
			i_q          <= '0;
			j_q          <= '0;
			clr_q        <= '0;
			prev_q       <= '0;
			cur_q        <= '0;
			next_q       <= '0;
			first_q      <= '0;
			new_q        <= '0;
			done_q       <= 1'b0;
			cell_alive_q <= 1'b0;
			oor_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ROWS_USED: rows_used_q <= cfg_data[ROWS_USED_W-1:0];
					REG_COLS_USED: cols_used_q <= cfg_data;
				endcase
			end
			done_q       <= 1'b0;
			cell_alive_q <= 1'b0;
			oor_q        <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + RW'(1);
					if (int'(clr_q) == MAX_ROWS - 1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						op_q    <= op_t'(op);
						row_q   <= RW'(row);
						col_q   <= CW'(col);
						alive_q <= alive;
						priority if (op_t'(op) == OP_ADVANCE) begin
							state_q <= S_GRD0;
						end else if (op_t'(op) == OP_NOP) begin
							done_q <= 1'b1;
						end else if (in_range) begin
							state_q <= S_ACC;
						end else begin
							done_q <= 1'b1;
							oor_q  <= 1'b1;
						end
					end
				end
				S_ACC: begin
					done_q       <= 1'b1;
					cell_alive_q <= (op_q == OP_READ) && rd_data[col_q];
					state_q      <= S_IDLE;
				end
				S_GRD0: begin
					prev_q  <= rd_data;
					i_q     <= '0;
					state_q <= S_GRD1;
				end
				S_GRD1: begin
					cur_q   <= rd_data;
					first_q <= rd_data;
					state_q <= S_GRDN;
				end
				S_GRDN: begin
					// row 0 is already rewritten when the bottom row wraps to it
					next_q  <= (dn_i == '0) ? first_q : rd_data;
					new_q   <= cur_q;
					j_q     <= '0;
					state_q <= S_GCELL;
				end
				S_GCELL: begin
					new_q[j_q] <= rule_bit;
					j_q        <= j_q + CW'(1);
					if (last_col) begin
						state_q <= S_GWR;
					end
				end
				S_GWR: begin
					if (last_row) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						prev_q  <= cur_q;
						cur_q   <= next_q;
						i_q     <= i_q + RW'(1);
						state_q <= S_GRDN;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done         = done_q;
	assign cell_alive   = cell_alive_q;
	assign out_of_range = oor_q;

endmodule

`default_nettype wire

FILE: hw/rtl/tlg_checker.sv
// Port-level checker for toroidal_life_generation and its bind.
`default_nettype none

`include "toroidal_life_generation_defines.svh"

module tlg_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] op,
	input logic       done,
	input logic       cell_alive,
	input logic       out_of_range
);

	import tlg_pkg::*;

	`TLG_ASSERT_IMP(a_done_not_busy, done, !busy)
	`TLG_ASSERT_IMP(a_result_exclusive, done, !(cell_alive && out_of_range))
	`TLG_ASSERT_NXT(a_advance_busy, start && !busy && (op == OP_ADVANCE), busy && !done)
	`TLG_ASSERT_NXT(a_nop_result, start && !busy && (op == OP_NOP),
		done && !cell_alive && !out_of_range)

endmodule

bind toroidal_life_generation tlg_checker u_tlg_checker (.*);

`default_nettype wire
